// ===== src/h265_rtp_depacketizer_core_macros.svh =====
// Assertion macros shared by the depacketizer RTL.
`ifndef H265_RTP_DEPACKETIZER_CORE_MACROS_SVH
`define H265_RTP_DEPACKETIZER_CORE_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define H265DP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define H265DP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== src/h265dp_pkg.sv =====
// Shared types and constants of the H.265 RTP depacketizer.
package h265dp_pkg;

  // Command queue between parser and output sequencer
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // One parsed input byte: up to three results.
  // pair: a second data byte (byte_b) follows byte_a; abort_lead: an abort mark
  // goes first. last applies to the final result of the command.
  typedef struct packed {
    logic        abort_lead;
    logic        pair;
    logic [7:0]  byte_a;
    logic [7:0]  byte_b;
    logic        valid;
    logic        frag;
    logic        first;
    logic        last;
    logic [31:0] ts;
  } cmd_t;

endpackage

// ===== src/h265dp_front.sv =====
// Packet parser: tracks header, NAL type, fragment and aggregate state per byte.
module h265dp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [7:0]        data_byte_i,
  input  logic [15:0]       packet_length_i,
  input  logic [31:0]       timestamp_i,
  output h265dp_pkg::cmd_t  cmd_o,
  output logic              cmd_valid_o
);
  import h265dp_pkg::*;

  localparam logic [1:0] ModeDrop   = 2'd0;
  localparam logic [1:0] ModeSingle = 2'd1;
  localparam logic [1:0] ModeFrag   = 2'd2;
  localparam logic [1:0] ModeAgg    = 2'd3;

  localparam logic [1:0] PhLenHi   = 2'd0;
  localparam logic [1:0] PhLenLo   = 2'd1;
  localparam logic [1:0] PhFirst   = 2'd2;
  localparam logic [1:0] PhBody    = 2'd3;

  localparam logic [5:0] TypeSingleMax = 6'd40;
  localparam logic [5:0] TypeAgg       = 6'd48;
  localparam logic [5:0] TypeFrag      = 6'd49;

  logic [15:0] pos_q, pos_d;
  logic [6:0]  hl_q, hl_d;
  logic [1:0]  mode_q, mode_d;
  logic        open_q, open_d;
  logic [7:0]  first_q, first_d;
  logic [7:0]  second_q, second_d;
  logic        end_q, end_d;
  logic [15:0] ubl_q, ubl_d;
  logic [7:0]  lhb_q, lhb_d;
  logic [1:0]  phase_q, phase_d;

  logic        last;
  logic [15:0] rem;
  logic [15:0] hl_ext;
  logic [15:0] p;
  logic [5:0]  nal_type;
  logic        closes;
  logic [15:0] size;
  logic [15:0] ubl_n;

  always_comb begin
    pos_d    = pos_q;
    hl_d     = hl_q;
    mode_d   = mode_q;
    open_d   = open_q;
    first_d  = first_q;
    second_d = second_q;
    end_d    = end_q;
    ubl_d    = ubl_q;
    lhb_d    = lhb_q;
    phase_d  = phase_q;
    cmd_o    = '0;
    cmd_o.ts = timestamp_i;
    cmd_valid_o = 1'b0;
    p        = '0;
    nal_type = data_byte_i[6:1];
    closes   = 1'b0;
    size     = {lhb_q, data_byte_i};
    ubl_n    = ubl_q - 16'd1;

    last = ({1'b0, pos_q} + 17'd1) >= {1'b0, packet_length_i};
    rem  = last ? 16'd0 : (packet_length_i - pos_q - 16'd1);

    if (pos_q == 16'd0) begin
      hl_d   = 7'd12 + {1'b0, data_byte_i[3:0], 2'b00};
      mode_d = ({9'd0, hl_d} < packet_length_i) ? ModeSingle : ModeDrop;
    end
    hl_ext = {9'd0, hl_d};

    if (mode_d != ModeDrop && pos_q >= hl_ext) begin
      p = pos_q - hl_ext;
      if (p == 16'd0) begin
        if (nal_type <= TypeSingleMax) begin
          mode_d = ModeSingle;
        end else if (nal_type == TypeFrag) begin
          // payload must hold both header bytes plus the FU header
          mode_d  = (({1'b0, hl_ext} + 17'd3) <= {1'b0, packet_length_i}) ? ModeFrag
                                                                            : ModeDrop;
          first_d = data_byte_i;
        end else if (nal_type == TypeAgg) begin
          mode_d  = ModeAgg;
          phase_d = PhLenHi;
        end else begin
          mode_d = ModeDrop;
        end
      end

      if (mode_d == ModeSingle) begin
        cmd_valid_o  = 1'b1;
        cmd_o.byte_a = data_byte_i;
        cmd_o.valid  = 1'b1;
        cmd_o.first  = (p == 16'd0);
        cmd_o.last   = last;
      end else if (mode_d == ModeFrag) begin
        if (p == 16'd1) begin
          second_d = data_byte_i;
        end else if (p == 16'd2) begin
          closes = data_byte_i[6] & last;
          end_d  = data_byte_i[6];
          if (data_byte_i[7]) begin
            cmd_valid_o      = 1'b1;
            cmd_o.abort_lead = open_q;
            cmd_o.pair       = 1'b1;
            cmd_o.byte_a     = (first_q & 8'h81) | {1'b0, data_byte_i[5:0], 1'b0};
            cmd_o.byte_b     = second_q;
            cmd_o.valid      = 1'b1;
            cmd_o.frag       = 1'b1;
            cmd_o.first      = 1'b1;
            cmd_o.last       = closes;
            open_d           = ~closes;
          end else if (open_q) begin
            if (closes) begin
              // end bit on a continuation with no data: pure end mark
              cmd_valid_o = 1'b1;
              cmd_o.frag  = 1'b1;
              cmd_o.last  = 1'b1;
              open_d      = 1'b0;
            end
          end else begin
            mode_d = ModeDrop;
          end
        end else if (p >= 16'd3 && open_q) begin
          closes       = end_q & last;
          cmd_valid_o  = 1'b1;
          cmd_o.byte_a = data_byte_i;
          cmd_o.valid  = 1'b1;
          cmd_o.frag   = 1'b1;
          cmd_o.last   = closes;
          if (closes) begin
            open_d = 1'b0;
          end
        end
      end else if (mode_d == ModeAgg && p >= 16'd2) begin
        unique case (phase_q)
          PhLenHi: begin
            lhb_d   = data_byte_i;
            phase_d = PhLenLo;
          end
          PhLenLo: begin
            if (size == 16'd0) begin
              phase_d = PhLenHi;
            end else if (size > rem) begin
              mode_d = ModeDrop;
            end else begin
              ubl_d   = size;
              phase_d = PhFirst;
            end
          end
          default: begin
            ubl_d        = ubl_n;
            cmd_valid_o  = 1'b1;
            cmd_o.byte_a = data_byte_i;
            cmd_o.valid  = 1'b1;
            cmd_o.first  = (phase_q == PhFirst);
            cmd_o.last   = (ubl_n == 16'd0);
            phase_d      = (ubl_n == 16'd0) ? PhLenHi : PhBody;
          end
        endcase
      end
    end

    pos_d = last ? 16'd0 : (pos_q + 16'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      hl_q     <= 7'd12;
      mode_q   <= ModeDrop;
      open_q   <= 1'b0;
      first_q  <= '0;
      second_q <= '0;
      end_q    <= 1'b0;
      ubl_q    <= '0;
      lhb_q    <= '0;
      phase_q  <= PhLenHi;
    end else if (fire_i) begin
      pos_q    <= pos_d;
      hl_q     <= hl_d;
      mode_q   <= mode_d;
      open_q   <= open_d;
      first_q  <= first_d;
      second_q <= second_d;
      end_q    <= end_d;
      ubl_q    <= ubl_d;
      lhb_q    <= lhb_d;
      phase_q  <= phase_d;
    end
  end

endmodule

// ===== src/h265dp_queue.sv =====
// Short command queue between the parser and the output sequencer.
`include "h265_rtp_depacketizer_core_macros.svh"

module h265dp_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  h265dp_pkg::cmd_t  cmd_i,
  output logic              full_o,
  input  logic              pop_i,
  output h265dp_pkg::cmd_t  head_o,
  output logic              empty_o
);
  import h265dp_pkg::*;

  cmd_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + QCntW'(1);
      2'b01:   cnt_d = cnt_q - QCntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QPtrW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  `H265DP_ASSERT(a_cnt_range, cnt_q <= QCntW'(QDepth), "queue count out of range")
  `H265DP_ASSERT_NEVER(a_overflow, push_i && full_o, "push into full queue")
  `H265DP_ASSERT_NEVER(a_underflow, pop_i && empty_o, "pop from empty queue")
  `H265DP_ASSERT(a_cnt_inc, (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + QCntW'(1)), "count did not advance on push")

endmodule

// ===== src/h265dp_back.sv =====
// Output sequencer: expands each command into results behind an output register.
`include "h265_rtp_depacketizer_core_macros.svh"

module h265dp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  h265dp_pkg::cmd_t  head_i,
  input  logic              q_empty_i,
  output logic              q_pop_o,
  output logic [7:0]        nal_byte_o,
  output logic              byte_valid_o,
  output logic              fragmented_o,
  output logic              nal_first_o,
  output logic              nal_last_o,
  output logic              abort_o,
  output logic [31:0]       out_timestamp_o,
  output logic              empty_o,
  input  logic              pop_i
);
  import h265dp_pkg::*;

  localparam logic [1:0] SelAbort = 2'd0;
  localparam logic [1:0] SelA     = 2'd1;
  localparam logic [1:0] SelB     = 2'd2;

  logic [1:0]  step_q, step_d;
  logic        out_valid_q, out_valid_d;
  logic        load;
  logic [1:0]  last_step;
  logic [1:0]  sel;
  logic [7:0]  r_byte;
  logic        r_valid, r_frag, r_first, r_last, r_abort;

  logic [7:0]  byte_q;
  logic        valid_q, frag_q, first_q, last_q, abort_q;
  logic [31:0] ts_q;

  assign load      = ~q_empty_i & (~out_valid_q | pop_i);
  assign last_step = {1'b0, head_i.abort_lead} + {1'b0, head_i.pair};
  assign sel       = head_i.abort_lead ? step_q : (step_q + 2'd1);
  assign q_pop_o   = load & (step_q == last_step);

  always_comb begin
    r_byte  = 8'd0;
    r_valid = 1'b0;
    r_frag  = 1'b0;
    r_first = 1'b0;
    r_last  = 1'b0;
    r_abort = 1'b0;
    unique case (sel)
      SelAbort: begin
        r_frag  = 1'b1;
        r_abort = 1'b1;
      end
      SelA: begin
        r_byte  = head_i.byte_a;
        r_valid = head_i.valid;
        r_frag  = head_i.frag;
        r_first = head_i.first;
        r_last  = head_i.pair ? 1'b0 : head_i.last;
      end
      SelB: begin
        r_byte  = head_i.byte_b;
        r_valid = 1'b1;
        r_frag  = head_i.frag;
        r_last  = head_i.last;
      end
      default: begin
        r_byte = 8'd0;
      end
    endcase
  end

  always_comb begin
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
      step_d      = (step_q == last_step) ? 2'd0 : (step_q + 2'd1);
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q  <= r_byte;
      valid_q <= r_valid;
      frag_q  <= r_frag;
      first_q <= r_first;
      last_q  <= r_last;
      abort_q <= r_abort;
      ts_q    <= head_i.ts;
    end
  end

  assign empty_o         = ~out_valid_q;
  assign nal_byte_o      = byte_q;
  assign byte_valid_o    = valid_q;
  assign fragmented_o    = frag_q;
  assign nal_first_o     = first_q;
  assign nal_last_o      = last_q;
  assign abort_o         = abort_q;
  assign out_timestamp_o = ts_q;

  `H265DP_ASSERT(a_step_needs_head, (step_q != 2'd0) |-> !q_empty_i, "mid-command step with empty queue")
  `H265DP_ASSERT(a_step_bound, !q_empty_i |-> (step_q <= last_step), "step past end of command")

endmodule

// ===== src/h265_rtp_depacketizer_core.sv =====
// H.265 RTP depacketizer top level: parser, command queue, output sequencer.
// Takes one RTP packet byte per clock while full is low and returns NAL unit bytes
// with first/last, fragment-channel and abort marks. Each input byte gives zero to
// three results; while pop is high they leave one per clock, each passing the
// command queue and then the output register before it reaches the result ports.
// A four-entry command queue sits between the parser and the output sequencer; a
// fragment start that gives two or three results on one byte takes one slot there
// but holds the sequencer for each result, and full rises only when the result
// side falls behind by more than the queue holds. With pop held high the block
// sustains one input byte per clock apart from such fragment starts.
module h265_rtp_depacketizer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic [15:0] packet_length_i,
  input  logic [31:0] timestamp_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  nal_byte_o,
  output logic        byte_valid_o,
  output logic        fragmented_o,
  output logic        nal_first_o,
  output logic        nal_last_o,
  output logic        abort_o,
  output logic [31:0] out_timestamp_o
);
  import h265dp_pkg::*;

  logic in_fire;
  cmd_t cmd;
  logic cmd_valid;
  logic q_full;
  cmd_t head;
  logic q_empty;
  logic q_pop;

  assign full    = q_full;
  assign in_fire = push & ~q_full;

  h265dp_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fire_i          (in_fire),
    .data_byte_i     (data_byte_i),
    .packet_length_i (packet_length_i),
    .timestamp_i     (timestamp_i),
    .cmd_o           (cmd),
    .cmd_valid_o     (cmd_valid)
  );

  h265dp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_fire & cmd_valid),
    .cmd_i   (cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .head_o  (head),
    .empty_o (q_empty)
  );

  h265dp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .q_empty_i       (q_empty),
    .q_pop_o         (q_pop),
    .nal_byte_o      (nal_byte_o),
    .byte_valid_o    (byte_valid_o),
    .fragmented_o    (fragmented_o),
    .nal_first_o     (nal_first_o),
    .nal_last_o      (nal_last_o),
    .abort_o         (abort_o),
    .out_timestamp_o (out_timestamp_o),
    .empty_o         (empty),
    .pop_i           (pop)
  );

endmodule
